>>> rtl/scoped_run_length_local_type_map_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scoped run-length local type map
// Same-cycle and next-cycle implication forms; they compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef SCOPED_RUN_LENGTH_LOCAL_TYPE_MAP_TOP_MACROS_SVH
`define SCOPED_RUN_LENGTH_LOCAL_TYPE_MAP_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SRLTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srltm: same-cycle check failed");
`define SRLTM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srltm: next-cycle check failed");
`else
`define SRLTM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SRLTM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/srltm_pkg.sv
// ----------------------------------------------------------------------------
// srltm_pkg
// Sizes, types and operation codes of the scoped run-length local type map.
// ----------------------------------------------------------------------------
package srltm_pkg;

	localparam int MAX_RUNS   = 64;
	localparam int MAX_SCOPES = 16;

	localparam int RUN_IW   = $clog2(MAX_RUNS);
	localparam int RUN_CW   = $clog2(MAX_RUNS + 1);
	localparam int SCOPE_IW = (MAX_SCOPES > 1) ? $clog2(MAX_SCOPES) : 1;
	localparam int SCOPE_CW = $clog2(MAX_SCOPES + 1);

	typedef logic [RUN_IW-1:0]   run_idx_t;
	typedef logic [RUN_CW-1:0]   run_cnt_t;
	typedef logic [SCOPE_IW-1:0] scope_idx_t;
	typedef logic [SCOPE_CW-1:0] scope_cnt_t;

	localparam run_cnt_t   RUN_FULL   = run_cnt_t'(MAX_RUNS);
	localparam scope_cnt_t SCOPE_FULL = scope_cnt_t'(MAX_SCOPES);

	typedef struct packed {
		logic [7:0]  run_type;
		logic [31:0] run_end;
	} run_entry_t;

	localparam int ENTRY_W = $bits(run_entry_t);

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_APPEND = 3'd1,
		OP_OPEN   = 3'd2,
		OP_CLOSE  = 3'd3,
		OP_LOOKUP = 3'd4
	} op_t;

endpackage

>>> rtl/srltm_ram.sv
// ----------------------------------------------------------------------------
// srltm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srltm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/scoped_run_length_local_type_map_top.sv
// ----------------------------------------------------------------------------
// scoped_run_length_local_type_map_top
// Clear, open, refused or empty-scope close, spare codes, zero or overflowing append and
// empty-list lookup finish at the decode; merge, insert and close walk the R pairs that
// follow the insertion point or the dropped pairs, insert then writes the new pair, a
// full store is refused after the previous-pair read; lookup scans to a match or the end.
// One transfer at a time, the next may land on the strobe's edge; the strobe cannot be
// held off. Reset (async, active low) empties the list and scopes.
// ----------------------------------------------------------------------------
`include "scoped_run_length_local_type_map_top_macros.svh"

module scoped_run_length_local_type_map_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [31:0] run_length,
	input  logic [7:0]  type_code,
	input  logic [31:0] local_index,
	output logic        done,
	output logic        ok,
	output logic        found,
	output logic [7:0]  found_type,
	output logic [31:0] total_locals
);

	// Sequencer states: CHECK decodes and issues the first memory read, PREV and
	// HELD consume that read, RUN streams the entry walk, INS writes a new pair.
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_PREV,
		S_HELD,
		S_RUN,
		S_INS
	} state_t;

	// What the entry walk does with each entry it reads.
	typedef enum logic [1:0] {
		M_RAISE,    // end += run_length, written in place (merge)
		M_SHIFT,    // end += run_length, written one slot up (insert)
		M_COMPACT,  // end -= held, written k slots down (close)
		M_SCAN      // compare local_index against end (lookup)
	} mode_t;

	state_t state_q;
	mode_t  mode_q;

	// Captured operation
	logic [2:0]  op_q;
	logic [31:0] n_q;
	logic [7:0]  ty_q;
	logic [31:0] idx_q;

	// Architectural state (the pair list itself lives in the RAM)
	srltm_pkg::run_cnt_t   rc_q;
	srltm_pkg::scope_cnt_t depth_q;
	srltm_pkg::run_cnt_t   spc_q [srltm_pkg::MAX_SCOPES];
	logic [31:0]           total_q;

	// Working registers of the current operation
	srltm_pkg::run_cnt_t at_q;        // insertion point, or k on close
	logic [31:0]         pend_total_q;
	logic [31:0]         prev_end_q;
	logic [31:0]         held_q;
	srltm_pkg::run_idx_t ptr_q;
	srltm_pkg::run_idx_t koff_q;
	srltm_pkg::run_cnt_t cnt_q;

	// Walk pipeline: read in one cycle, modify and write in the next
	logic                v_s1;
	srltm_pkg::run_idx_t waddr_s1;

	// Result registers
	logic       done_q;
	logic       ok_q;
	logic       found_q;
	logic [7:0] found_type_q;

	// RAM port signals
	logic                   ram_we;
	srltm_pkg::run_idx_t    ram_waddr;
	srltm_pkg::run_entry_t  ram_wdata;
	srltm_pkg::run_idx_t    ram_raddr;
	logic [srltm_pkg::ENTRY_W-1:0] ram_rdata;
	srltm_pkg::run_entry_t  rd;

	// Shared adder
	logic [31:0] add_a;
	logic [31:0] add_b;
	logic        add_ci;
	logic [32:0] sum;

	// Scope decode
	srltm_pkg::scope_idx_t top_idx;
	srltm_pkg::run_cnt_t   spc_top;
	srltm_pkg::run_cnt_t   at_c;
	logic                  prev_match;
	srltm_pkg::run_idx_t   waddr_next;

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign ok           = ok_q;
	assign found        = found_q;
	assign found_type   = found_type_q;
	assign total_locals = total_q;

	assign rd = ram_rdata;

	// Innermost scope and its insertion point, clamped to the list length.
	assign top_idx = srltm_pkg::scope_idx_t'(depth_q - 1'b1);
	assign spc_top = spc_q[top_idx];
	assign at_c    = (spc_top > rc_q) ? rc_q : spc_top;

	// Pair before the insertion point carries the same type: merge into it.
	assign prev_match = (at_q != '0) && (rd.run_type == ty_q);

	// One adder serves the overflow check, every end update, the new totals
	// and the lookup compare (carry out of end + ~index means end > index).
	always_comb begin
		add_a  = total_q;
		add_b  = n_q;
		add_ci = 1'b0;
		case (state_q)
			S_PREV: begin
				add_a = rd.run_end;
			end
			S_HELD: begin
				add_b  = ~rd.run_end;
				add_ci = 1'b1;
			end
			S_RUN: begin
				add_a = rd.run_end;
				case (mode_q)
					M_COMPACT: begin
						add_b  = ~held_q;
						add_ci = 1'b1;
					end
					M_SCAN: begin
						add_b = ~idx_q;
					end
					default: begin
						add_b = n_q;
					end
				endcase
			end
			S_INS: begin
				add_a = prev_end_q;
			end
			default: begin
				add_a = total_q;
			end
		endcase
	end

	assign sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_ci};

	// Write slot of the entry being read, per walk mode.
	always_comb begin
		case (mode_q)
			M_SHIFT:   waddr_next = ptr_q + 1'b1;
			M_COMPACT: waddr_next = ptr_q - koff_q;
			default:   waddr_next = ptr_q;
		endcase
	end

	// RAM access: reads are issued from CHECK (entry before the insertion point,
	// or the last pair of the closing scope) and from the walk; writes come from
	// the merge, the walk's second stage and the final insert.
	always_comb begin
		ram_raddr = ptr_q;
		ram_we    = 1'b0;
		ram_waddr = waddr_s1;
		ram_wdata = '{run_type: rd.run_type, run_end: sum[31:0]};
		case (state_q)
			S_CHECK: begin
				ram_raddr = srltm_pkg::run_idx_t'(at_c - 1'b1);
			end
			S_PREV: begin
				ram_we    = prev_match;
				ram_waddr = srltm_pkg::run_idx_t'(at_q - 1'b1);
			end
			S_RUN: begin
				ram_we = v_s1 && (mode_q != M_SCAN);
			end
			S_INS: begin
				ram_we    = 1'b1;
				ram_waddr = srltm_pkg::run_idx_t'(at_q);
				ram_wdata = '{run_type: ty_q, run_end: sum[31:0]};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	srltm_ram #(
		.WIDTH (srltm_pkg::ENTRY_W),
		.DEPTH (srltm_pkg::MAX_RUNS)
	) u_runs (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer, architectural state and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= M_SCAN;
			rc_q         <= '0;
			depth_q      <= srltm_pkg::scope_cnt_t'(1);
			total_q      <= '0;
			v_s1         <= 1'b0;
			done_q       <= 1'b0;
			ok_q         <= 1'b0;
			found_q      <= 1'b0;
			found_type_q <= '0;
			cnt_q        <= '0;
			for (int i = 0; i < srltm_pkg::MAX_SCOPES; i++) begin
				spc_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						// Capture the transfer and clear the lookup result fields.
						op_q         <= operation;
						n_q          <= run_length;
						ty_q         <= type_code;
						idx_q        <= local_index;
						found_q      <= 1'b0;
						found_type_q <= '0;
						state_q      <= S_CHECK;
					end
				end

				S_CHECK: begin
					unique case (op_q)
						srltm_pkg::OP_CLEAR: begin
							rc_q     <= '0;
							depth_q  <= srltm_pkg::scope_cnt_t'(1);
							spc_q[0] <= '0;
							total_q  <= '0;
							ok_q     <= 1'b1;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end
						srltm_pkg::OP_APPEND: begin
							if (n_q == '0) begin
								ok_q    <= 1'b1;
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else if (sum[32]) begin
								// Total would pass 2^32-1: refuse.
								ok_q    <= 1'b0;
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								at_q         <= at_c;
								pend_total_q <= sum[31:0];
								state_q      <= S_PREV;
							end
						end
						srltm_pkg::OP_OPEN: begin
							if (depth_q < srltm_pkg::SCOPE_FULL) begin
								spc_q[srltm_pkg::scope_idx_t'(depth_q)] <= '0;
								depth_q <= depth_q + 1'b1;
								ok_q    <= 1'b1;
							end else begin
								ok_q <= 1'b0;
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						srltm_pkg::OP_CLOSE: begin
							if (depth_q <= srltm_pkg::scope_cnt_t'(1)) begin
								ok_q    <= 1'b0;
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								depth_q <= depth_q - 1'b1;
								if (at_c == '0) begin
									ok_q    <= 1'b1;
									done_q  <= 1'b1;
									state_q <= S_IDLE;
								end else begin
									at_q    <= at_c;
									state_q <= S_HELD;
								end
							end
						end
						srltm_pkg::OP_LOOKUP: begin
							if (rc_q == '0) begin
								ok_q    <= 1'b1;
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								mode_q  <= M_SCAN;
								ptr_q   <= '0;
								cnt_q   <= rc_q;
								v_s1    <= 1'b0;
								state_q <= S_RUN;
							end
						end
						default: begin
							ok_q    <= 1'b0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end

				S_PREV: begin
					if (prev_match) begin
						// Merge written this cycle; raise the ends behind it.
						total_q <= pend_total_q;
						if (rc_q == at_q) begin
							ok_q    <= 1'b1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							mode_q  <= M_RAISE;
							ptr_q   <= srltm_pkg::run_idx_t'(at_q);
							cnt_q   <= rc_q - at_q;
							v_s1    <= 1'b0;
							state_q <= S_RUN;
						end
					end else if (rc_q == srltm_pkg::RUN_FULL) begin
						ok_q    <= 1'b0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						// Insert: move the tail up one slot, then write the new pair.
						total_q        <= pend_total_q;
						rc_q           <= rc_q + 1'b1;
						spc_q[top_idx] <= at_q + 1'b1;
						prev_end_q     <= (at_q != '0) ? rd.run_end : 32'd0;
						if (rc_q == at_q) begin
							state_q <= S_INS;
						end else begin
							mode_q  <= M_SHIFT;
							ptr_q   <= srltm_pkg::run_idx_t'(rc_q - 1'b1);
							cnt_q   <= rc_q - at_q;
							v_s1    <= 1'b0;
							state_q <= S_RUN;
						end
					end
				end

				S_HELD: begin
					// Drop the scope's k pairs; the rest moves down and is lowered.
					held_q  <= rd.run_end;
					total_q <= sum[31:0];
					rc_q    <= rc_q - at_q;
					if (rc_q == at_q) begin
						ok_q    <= 1'b1;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						mode_q  <= M_COMPACT;
						ptr_q   <= srltm_pkg::run_idx_t'(at_q);
						koff_q  <= srltm_pkg::run_idx_t'(at_q);
						cnt_q   <= rc_q - at_q;
						v_s1    <= 1'b0;
						state_q <= S_RUN;
					end
				end

				S_RUN: begin
					// Advance the read side while entries remain.
					if (cnt_q != '0) begin
						v_s1     <= 1'b1;
						waddr_s1 <= waddr_next;
						ptr_q    <= (mode_q == M_SHIFT) ? ptr_q - 1'b1 : ptr_q + 1'b1;
						cnt_q    <= cnt_q - 1'b1;
					end else begin
						v_s1 <= 1'b0;
					end
					if ((mode_q == M_SCAN) && v_s1 && sum[32]) begin
						found_q      <= 1'b1;
						found_type_q <= rd.run_type;
						ok_q         <= 1'b1;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else if (cnt_q == '0) begin
						// Last entry is written (or compared) this cycle.
						if (mode_q == M_SHIFT) begin
							state_q <= S_INS;
						end else begin
							ok_q    <= 1'b1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end

				S_INS: begin
					ok_q    <= 1'b1;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SRLTM_ASSERT_IMP(a_run_count_bound, clk, arst_n, 1'b1, rc_q <= srltm_pkg::RUN_FULL)
	`SRLTM_ASSERT_IMP(a_depth_bound, clk, arst_n, 1'b1,
		(depth_q != '0) && (depth_q <= srltm_pkg::SCOPE_FULL))
	`SRLTM_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`SRLTM_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`SRLTM_ASSERT_IMP(a_found_ok, clk, arst_n, done && found,
		ok && (op_q == srltm_pkg::OP_LOOKUP))

endmodule
